// ===== rtl/quadrilateral_shape_classifier_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the quadrilateral shape classifier
// Clocked on clk and switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef QUADRILATERAL_SHAPE_CLASSIFIER_ASSERT_SVH
`define QUADRILATERAL_SHAPE_CLASSIFIER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define QSC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("quadrilateral shape classifier check failed");

// Consequent checked in the cycle after the antecedent.
`define QSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("quadrilateral shape classifier check failed");

`endif

// ===== rtl/qsc_pkg.sv =====
// ----------------------------------------------------------------------------
// qsc_pkg
// Shared types and constants of the quadrilateral shape classifier.
// ----------------------------------------------------------------------------
package qsc_pkg;

    localparam int COORD_BITS_DEF = 16;

    // Valid shift line depth, from the input register to the result register.
    localparam int PIPE_DEPTH = 9;

    // Slots of the length vector: four sides, then the two diagonals.
    localparam int N_LEN  = 6;
    localparam int LEN_S0 = 0;
    localparam int LEN_S1 = 1;
    localparam int LEN_S2 = 2;
    localparam int LEN_S3 = 3;
    localparam int LEN_D1 = 4;
    localparam int LEN_D2 = 5;

    typedef enum logic [2:0] {
        SHAPE_SQUARE        = 3'd0,
        SHAPE_RECTANGLE     = 3'd1,
        SHAPE_RHOMBUS       = 3'd2,
        SHAPE_PARALLELOGRAM = 3'd3,
        SHAPE_TRAPEZIUM     = 3'd4,
        SHAPE_ORDINARY      = 3'd5
    } shape_t;

    // Sign of a sum of two products; both flags low means zero.
    typedef struct packed {
        logic pos;
        logic neg;
    } sign_t;

endpackage

// ===== rtl/quadrilateral_shape_classifier.sv =====
// ----------------------------------------------------------------------------
// quadrilateral_shape_classifier
// Orders four corners by cross-product side tests, then classifies the shape
// from exact squared side and diagonal lengths and two parallel-side tests.
// Output: done and shape_code come from registers and appear together.
// Throughput: one item per cycle; busy stays low, the nine-stage pipeline
// never stalls and the receiver cannot hold results off.
// Reset: rst_n clears the valid shift line at once; no result follows it.
// ----------------------------------------------------------------------------
`include "quadrilateral_shape_classifier_assert.svh"

module quadrilateral_shape_classifier #(
    parameter int COORD_BITS = qsc_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] x_a,
    input  logic signed [COORD_BITS-1:0] y_a,
    input  logic signed [COORD_BITS-1:0] x_b,
    input  logic signed [COORD_BITS-1:0] y_b,
    input  logic signed [COORD_BITS-1:0] x_c,
    input  logic signed [COORD_BITS-1:0] y_c,
    input  logic signed [COORD_BITS-1:0] x_d,
    input  logic signed [COORD_BITS-1:0] y_d,
    output logic                         done,
    output logic [2:0]                   shape_code
);

    localparam int DW    = COORD_BITS + 1;
    localparam int LW    = 2 * DW;
    localparam int DEPTH = qsc_pkg::PIPE_DEPTH;

    logic                  accept;
    logic [DEPTH-1:0]      valid_reg;
    logic [DEPTH-1:0]      valid_next;

    // Stage 0: input coordinates.
    logic signed [COORD_BITS-1:0] px_reg [4];
    logic signed [COORD_BITS-1:0] py_reg [4];

    // Stage 1: differences for the ordering tests.
    logic signed [DW-1:0] dx10_reg, dx20_reg, dx30_reg;
    logic signed [DW-1:0] dy10_reg, dy20_reg, dy30_reg;
    logic signed [DW-1:0] dy01_reg, dy03_reg;

    // Points travel alongside the side-test lanes.
    logic signed [COORD_BITS-1:0] pdx_reg [3][4];
    logic signed [COORD_BITS-1:0] pdy_reg [3][4];

    qsc_pkg::sign_t sgn_s1, sgn_s2, sgn_t1, sgn_t2;
    logic           swap_12, swap_23;

    // Stage 4: corners in boundary order.
    logic signed [COORD_BITS-1:0] ox_reg [4];
    logic signed [COORD_BITS-1:0] oy_reg [4];
    logic signed [COORD_BITS-1:0] ox_next [4];
    logic signed [COORD_BITS-1:0] oy_next [4];

    // Stage 5: side and diagonal differences.
    logic signed [DW-1:0] ddx_reg [qsc_pkg::N_LEN];
    logic signed [DW-1:0] ddy_reg [qsc_pkg::N_LEN];
    logic signed [DW-1:0] ngx_reg [2];

    logic [qsc_pkg::N_LEN-1:0][LW-1:0] len;
    qsc_pkg::sign_t                    par_a, par_b;
    qsc_pkg::shape_t                   code;

    function automatic logic signed [DW-1:0] sdiff(
        input logic signed [COORD_BITS-1:0] p,
        input logic signed [COORD_BITS-1:0] q
    );
        sdiff = DW'(p) - DW'(q);
    endfunction

    assign accept     = start && !busy;
    assign busy       = 1'b0;
    assign valid_next = {valid_reg[DEPTH-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg <= '{x_a, x_b, x_c, x_d};
        py_reg <= '{y_a, y_b, y_c, y_d};

        dx10_reg <= sdiff(px_reg[1], px_reg[0]);
        dx20_reg <= sdiff(px_reg[2], px_reg[0]);
        dx30_reg <= sdiff(px_reg[3], px_reg[0]);
        dy10_reg <= sdiff(py_reg[1], py_reg[0]);
        dy20_reg <= sdiff(py_reg[2], py_reg[0]);
        dy30_reg <= sdiff(py_reg[3], py_reg[0]);
        dy01_reg <= sdiff(py_reg[0], py_reg[1]);
        dy03_reg <= sdiff(py_reg[0], py_reg[3]);

        pdx_reg[0] <= px_reg;
        pdy_reg[0] <= py_reg;
        pdx_reg[1] <= pdx_reg[0];
        pdy_reg[1] <= pdy_reg[0];
        pdx_reg[2] <= pdx_reg[1];
        pdy_reg[2] <= pdy_reg[1];

        ox_reg <= ox_next;
        oy_reg <= oy_next;

        ddx_reg[qsc_pkg::LEN_S0] <= sdiff(ox_reg[0], ox_reg[1]);
        ddy_reg[qsc_pkg::LEN_S0] <= sdiff(oy_reg[0], oy_reg[1]);
        ddx_reg[qsc_pkg::LEN_S1] <= sdiff(ox_reg[1], ox_reg[2]);
        ddy_reg[qsc_pkg::LEN_S1] <= sdiff(oy_reg[1], oy_reg[2]);
        ddx_reg[qsc_pkg::LEN_S2] <= sdiff(ox_reg[2], ox_reg[3]);
        ddy_reg[qsc_pkg::LEN_S2] <= sdiff(oy_reg[2], oy_reg[3]);
        ddx_reg[qsc_pkg::LEN_S3] <= sdiff(ox_reg[3], ox_reg[0]);
        ddy_reg[qsc_pkg::LEN_S3] <= sdiff(oy_reg[3], oy_reg[0]);
        ddx_reg[qsc_pkg::LEN_D1] <= sdiff(ox_reg[0], ox_reg[2]);
        ddy_reg[qsc_pkg::LEN_D1] <= sdiff(oy_reg[0], oy_reg[2]);
        ddx_reg[qsc_pkg::LEN_D2] <= sdiff(ox_reg[1], ox_reg[3]);
        ddy_reg[qsc_pkg::LEN_D2] <= sdiff(oy_reg[1], oy_reg[3]);
        // Negated x components of the first sides of the two parallel tests.
        ngx_reg[0] <= sdiff(ox_reg[1], ox_reg[0]);
        ngx_reg[1] <= sdiff(ox_reg[2], ox_reg[1]);
    end

    // Side tests against the line through corners 1 and 2.
    qsc_sign_lane #(.W(DW)) u_side_s1 (
        .clk (clk), .a (dx20_reg), .b (dy01_reg), .c (dy20_reg), .d (dx10_reg),
        .sgn (sgn_s1)
    );
    qsc_sign_lane #(.W(DW)) u_side_s2 (
        .clk (clk), .a (dx30_reg), .b (dy01_reg), .c (dy30_reg), .d (dx10_reg),
        .sgn (sgn_s2)
    );

    // Side tests against the line through corners 1 and 4.
    qsc_sign_lane #(.W(DW)) u_side_t1 (
        .clk (clk), .a (dx10_reg), .b (dy03_reg), .c (dy10_reg), .d (dx30_reg),
        .sgn (sgn_t1)
    );
    qsc_sign_lane #(.W(DW)) u_side_t2 (
        .clk (clk), .a (dx20_reg), .b (dy03_reg), .c (dy20_reg), .d (dx30_reg),
        .sgn (sgn_t2)
    );

    // A zero result never counts as lying on the opposite side.
    assign swap_12 = (sgn_s1.pos && sgn_s2.neg) || (sgn_s1.neg && sgn_s2.pos);
    assign swap_23 = (sgn_t1.pos && sgn_t2.neg) || (sgn_t1.neg && sgn_t2.pos);

    always_comb
    begin
        ox_next = pdx_reg[2];
        oy_next = pdy_reg[2];
        priority if (swap_12)
        begin
            ox_next[1] = pdx_reg[2][2];
            oy_next[1] = pdy_reg[2][2];
            ox_next[2] = pdx_reg[2][1];
            oy_next[2] = pdy_reg[2][1];
        end
        else if (swap_23)
        begin
            ox_next[2] = pdx_reg[2][3];
            oy_next[2] = pdy_reg[2][3];
            ox_next[3] = pdx_reg[2][2];
            oy_next[3] = pdy_reg[2][2];
        end
        else
        begin
            ox_next = pdx_reg[2];
            oy_next = pdy_reg[2];
        end
    end

    for (genvar i = 0; i < qsc_pkg::N_LEN; i++)
    begin : g_len
        qsc_len_lane #(.W(DW)) u_len (
            .clk (clk),
            .dx  (ddx_reg[i]),
            .dy  (ddy_reg[i]),
            .len (len[i])
        );
    end

    // Side 1-2 against side 3-4, and side 2-3 against side 4-1.
    qsc_sign_lane #(.W(DW)) u_par_a (
        .clk (clk),
        .a   (ddx_reg[qsc_pkg::LEN_S2]), .b (ddy_reg[qsc_pkg::LEN_S0]),
        .c   (ngx_reg[0]),               .d (ddy_reg[qsc_pkg::LEN_S2]),
        .sgn (par_a)
    );
    qsc_sign_lane #(.W(DW)) u_par_b (
        .clk (clk),
        .a   (ddx_reg[qsc_pkg::LEN_S3]), .b (ddy_reg[qsc_pkg::LEN_S1]),
        .c   (ngx_reg[1]),               .d (ddy_reg[qsc_pkg::LEN_S3]),
        .sgn (par_b)
    );

    qsc_classify #(.LW(LW)) u_classify (
        .clk   (clk),
        .len   (len),
        .par_a (par_a),
        .par_b (par_b),
        .code  (code)
    );

    assign done       = valid_reg[DEPTH-1];
    assign shape_code = code;

    `QSC_ASSERT_SAME(a_done_traces_beat, done, $past(valid_reg[0], DEPTH - 1))
    `QSC_ASSERT_SAME(a_first_corner_fixed, valid_reg[4], (ox_reg[0] == $past(pdx_reg[2][0])) && (oy_reg[0] == $past(pdy_reg[2][0])))
    `QSC_ASSERT_NEXT(a_unequal_sides, valid_reg[7] && (len[qsc_pkg::LEN_S0] != len[qsc_pkg::LEN_S2]), (shape_code == qsc_pkg::SHAPE_TRAPEZIUM) || (shape_code == qsc_pkg::SHAPE_ORDINARY))

endmodule

// ===== rtl/qsc_sign_lane.sv =====
// ----------------------------------------------------------------------------
// qsc_sign_lane
// Two-stage lane giving the sign of a*b + c*d for signed operands.
// ----------------------------------------------------------------------------
module qsc_sign_lane #(
    parameter int W = qsc_pkg::COORD_BITS_DEF + 1
) (
    input  logic                clk,
    input  logic signed [W-1:0] a,
    input  logic signed [W-1:0] b,
    input  logic signed [W-1:0] c,
    input  logic signed [W-1:0] d,
    output qsc_pkg::sign_t      sgn
);

    localparam int PW = 2 * W;

    logic signed [PW-1:0] p_reg;
    logic signed [PW-1:0] q_reg;
    logic signed [PW:0]   sum_next;
    qsc_pkg::sign_t       sgn_reg;
    qsc_pkg::sign_t       sgn_next;

    always_ff @(posedge clk)
    begin
        p_reg   <= a * b;
        q_reg   <= c * d;
        sgn_reg <= sgn_next;
    end

    // One extra bit keeps the sum exact.
    always_comb
    begin
        sum_next     = (PW + 1)'(p_reg) + (PW + 1)'(q_reg);
        sgn_next.neg = sum_next[PW];
        sgn_next.pos = !sum_next[PW] && (sum_next != '0);
    end

    assign sgn = sgn_reg;

endmodule

// ===== rtl/qsc_len_lane.sv =====
// ----------------------------------------------------------------------------
// qsc_len_lane
// Two-stage lane giving the exact squared length dx*dx + dy*dy.
// ----------------------------------------------------------------------------
module qsc_len_lane #(
    parameter int W = qsc_pkg::COORD_BITS_DEF + 1
) (
    input  logic                clk,
    input  logic signed [W-1:0] dx,
    input  logic signed [W-1:0] dy,
    output logic [2*W-1:0]      len
);

    localparam int LW = 2 * W;

    logic signed [LW-1:0] sq_x_reg;
    logic signed [LW-1:0] sq_y_reg;
    logic [LW-1:0]        len_reg;
    logic [LW-1:0]        len_next;

    always_ff @(posedge clk)
    begin
        sq_x_reg <= dx * dx;
        sq_y_reg <= dy * dy;
        len_reg  <= len_next;
    end

    // Each square is at most a quarter of the range, so the sum fits.
    assign len_next = $unsigned(sq_x_reg) + $unsigned(sq_y_reg);
    assign len      = len_reg;

endmodule

// ===== rtl/qsc_classify.sv =====
// ----------------------------------------------------------------------------
// qsc_classify
// Merging stage: turns the six lengths and two parallel tests into a code.
// ----------------------------------------------------------------------------
module qsc_classify #(
    parameter int LW = 2 * (qsc_pkg::COORD_BITS_DEF + 1)
) (
    input  logic                              clk,
    input  logic [qsc_pkg::N_LEN-1:0][LW-1:0] len,
    input  qsc_pkg::sign_t                    par_a,
    input  qsc_pkg::sign_t                    par_b,
    output qsc_pkg::shape_t                   code
);

    qsc_pkg::shape_t code_reg;
    qsc_pkg::shape_t code_next;
    logic            opp_equal;
    logic            all_equal;
    logic            diag_equal;
    logic            has_parallel;

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
    end

    always_comb
    begin
        opp_equal    = (len[qsc_pkg::LEN_S0] == len[qsc_pkg::LEN_S2])
                    && (len[qsc_pkg::LEN_S1] == len[qsc_pkg::LEN_S3]);
        all_equal    = (len[qsc_pkg::LEN_S0] == len[qsc_pkg::LEN_S1]);
        diag_equal   = (len[qsc_pkg::LEN_D1] == len[qsc_pkg::LEN_D2]);
        // A zero cross product means the two sides are parallel.
        has_parallel = (!par_a.pos && !par_a.neg) || (!par_b.pos && !par_b.neg);

        priority if (opp_equal && all_equal)
        begin
            code_next = diag_equal ? qsc_pkg::SHAPE_SQUARE : qsc_pkg::SHAPE_RHOMBUS;
        end
        else if (opp_equal)
        begin
            code_next = diag_equal ? qsc_pkg::SHAPE_RECTANGLE
                                   : qsc_pkg::SHAPE_PARALLELOGRAM;
        end
        else if (has_parallel)
        begin
            code_next = qsc_pkg::SHAPE_TRAPEZIUM;
        end
        else
        begin
            code_next = qsc_pkg::SHAPE_ORDINARY;
        end
    end

    assign code = code_reg;

endmodule

// ===== verif/tb_quadrilateral_shape_classifier.sv =====
// ----------------------------------------------------------------------------
// tb_quadrilateral_shape_classifier
// Self-checking bench for the quadrilateral shape classifier. A short table of
// hand-picked corner sets is followed by random sets built as squares,
// rectangles, rhombi, parallelograms, trapezia, degenerate and wide-range
// quadrilaterals, given in shuffled corner order. Each shape code is checked
// against the table or a local predictor, with random gaps between start beats.
// ----------------------------------------------------------------------------
module tb_quadrilateral_shape_classifier;

    localparam int COORD_W      = qsc_pkg::COORD_BITS_DEF;
    localparam int N_DIR        = 21;
    localparam int RANDOM_ITEMS = 630;
    localparam int QUIET_TAIL   = 120;
    localparam int USE_MODEL    = -1;
    localparam int WATCHDOG     = 2_000_000;

    // Coordinates of one corner set: x_a, y_a, x_b, y_b, x_c, y_c, x_d, y_d.
    typedef logic [7:0][COORD_W-1:0] quad_t;

    typedef enum int {
        MIX_SQUARE,
        MIX_RECT,
        MIX_RHOMBUS,
        MIX_PARA,
        MIX_TRAP,
        MIX_LINE,
        MIX_GRID,
        MIX_WIDE,
        MIX_CORNER
    } mix_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic signed [COORD_W-1:0] x_a = '0;
    logic signed [COORD_W-1:0] y_a = '0;
    logic signed [COORD_W-1:0] x_b = '0;
    logic signed [COORD_W-1:0] y_b = '0;
    logic signed [COORD_W-1:0] x_c = '0;
    logic signed [COORD_W-1:0] y_c = '0;
    logic signed [COORD_W-1:0] x_d = '0;
    logic signed [COORD_W-1:0] y_d = '0;
    logic                      done;
    logic [2:0]                shape_code;

    qsc_pkg::shape_t pending_shapes[$];
    qsc_pkg::shape_t want_shape;
    int              mismatches = 0;

    // The last column holds the shape code where it is obvious, else USE_MODEL.
    int dir_tab [N_DIR][9] = '{
        '{0, 0, 0, 0, 0, 0, 0, 0, qsc_pkg::SHAPE_SQUARE},
        '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
          qsc_pkg::SHAPE_SQUARE},
        '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
          qsc_pkg::SHAPE_SQUARE},
        '{-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767,
          qsc_pkg::SHAPE_SQUARE},
        '{-32768, -32768, 32767, 32767, 32767, -32768, -32768, 32767, USE_MODEL},
        '{0, 0, 4, 0, 4, 2, 0, 2, USE_MODEL},
        '{0, 0, 2, 1, 4, 0, 2, -1, USE_MODEL},
        '{0, 0, 4, 0, 5, 2, 1, 2, USE_MODEL},
        '{0, 0, 6, 0, 4, 3, 1, 3, USE_MODEL},
        '{0, 0, 5, 1, 3, 7, -2, 4, USE_MODEL},
        '{0, 0, 1, 0, 2, 0, 3, 0, USE_MODEL},
        '{5, 5, 5, 5, 5, 5, -7, 9, USE_MODEL},
        '{0, 0, 2, 0, 1, 1, 5, 0, USE_MODEL},
        '{0, 0, 2, 1, 2, -1, 4, 0, USE_MODEL},
        '{0, 0, 4, 2, 4, 0, 0, 2, USE_MODEL},
        '{-32768, -32768, 32767, -32768, 32767, 0, -32768, 0, USE_MODEL},
        '{-32768, 0, 0, 32767, 32767, 0, 0, -32768, USE_MODEL},
        '{32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767, USE_MODEL},
        '{-1, -1, 1, -1, 1, 1, -1, 1, USE_MODEL},
        '{32767, 32767, -32768, -32768, 0, 0, -1, 1, USE_MODEL},
        '{1, 1, 1, 1, 1, 1, 1, 1, USE_MODEL}
    };

    int rim_vals [7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};

    quadrilateral_shape_classifier #(
        .COORD_BITS(COORD_W)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .x_a        (x_a),
        .y_a        (y_a),
        .x_b        (x_b),
        .y_b        (y_b),
        .x_c        (x_c),
        .y_c        (y_c),
        .x_d        (x_d),
        .y_d        (y_d),
        .done       (done),
        .shape_code (shape_code)
    );

    always #6 clk = ~clk;

    // Sign of a*b + c*d; the operands are small enough for the sum to be exact.
    function automatic int turn_sign(input longint a, input longint b,
                                     input longint c, input longint d);
        longint sum;
        sum = a * b + c * d;
        return (sum > 0) ? 1 : ((sum < 0) ? -1 : 0);
    endfunction

    function automatic longint sq_span(input longint x0, input longint y0,
                                       input longint x1, input longint y1);
        return (x0 - x1) * (x0 - x1) + (y0 - y1) * (y0 - y1);
    endfunction

    function automatic bit is_parallel(input longint ux, input longint uy,
                                       input longint vx, input longint vy);
        return vx * uy == ux * vy;
    endfunction

    function automatic qsc_pkg::shape_t classify_quad(input quad_t q);
        longint cx [4];
        longint cy [4];
        longint tmp;
        longint side [4];
        longint diag_ac;
        longint diag_bd;
        int     s_c;
        int     s_d;
        for (int i = 0; i < 4; i++)
        begin
            cx[i] = $signed(q[2*i]);
            cy[i] = $signed(q[2*i+1]);
        end
        // Put the corners in boundary order: a strictly opposite side test
        // against edge a-b swaps b and c, otherwise one against edge a-d
        // swaps c and d.
        s_c = turn_sign(cx[2] - cx[0], cy[0] - cy[1], cy[2] - cy[0], cx[1] - cx[0]);
        s_d = turn_sign(cx[3] - cx[0], cy[0] - cy[1], cy[3] - cy[0], cx[1] - cx[0]);
        if (s_c * s_d < 0)
        begin
            tmp = cx[1]; cx[1] = cx[2]; cx[2] = tmp;
            tmp = cy[1]; cy[1] = cy[2]; cy[2] = tmp;
        end
        else
        begin
            s_c = turn_sign(cx[1] - cx[0], cy[0] - cy[3], cy[1] - cy[0], cx[3] - cx[0]);
            s_d = turn_sign(cx[2] - cx[0], cy[0] - cy[3], cy[2] - cy[0], cx[3] - cx[0]);
            if (s_c * s_d < 0)
            begin
                tmp = cx[2]; cx[2] = cx[3]; cx[3] = tmp;
                tmp = cy[2]; cy[2] = cy[3]; cy[3] = tmp;
            end
        end
        for (int i = 0; i < 4; i++)
            side[i] = sq_span(cx[i], cy[i], cx[(i+1)%4], cy[(i+1)%4]);
        diag_ac = sq_span(cx[0], cy[0], cx[2], cy[2]);
        diag_bd = sq_span(cx[1], cy[1], cx[3], cy[3]);
        if (side[0] == side[2] && side[1] == side[3])
        begin
            if (side[0] == side[1])
                return (diag_ac == diag_bd) ? qsc_pkg::SHAPE_SQUARE
                                            : qsc_pkg::SHAPE_RHOMBUS;
            return (diag_ac == diag_bd) ? qsc_pkg::SHAPE_RECTANGLE
                                        : qsc_pkg::SHAPE_PARALLELOGRAM;
        end
        if (is_parallel(cx[0] - cx[1], cy[0] - cy[1], cx[2] - cx[3], cy[2] - cy[3]) ||
            is_parallel(cx[1] - cx[2], cy[1] - cy[2], cx[3] - cx[0], cy[3] - cy[0]))
            return qsc_pkg::SHAPE_TRAPEZIUM;
        return qsc_pkg::SHAPE_ORDINARY;
    endfunction

    // Holds the corner set on the ports until the start beat is taken, then
    // records its shape and may leave a gap before the next one.
    task automatic send_item(input quad_t q, input int pinned, input bit no_gap);
        int gap;
        start <= 1'b1;
        x_a   <= q[0];
        y_a   <= q[1];
        x_b   <= q[2];
        y_b   <= q[3];
        x_c   <= q[4];
        y_c   <= q[5];
        x_d   <= q[6];
        y_d   <= q[7];
        do
            @(posedge clk);
        while (busy !== 1'b0);
        pending_shapes.push_back((pinned == USE_MODEL) ? classify_quad(q)
                                                       : qsc_pkg::shape_t'(pinned));
        if (!no_gap && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 7);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done !== 1'b0)
        begin
            if (pending_shapes.size() == 0)
            begin
                $display("%0t: result beat with none expected, expected none actual %0d",
                         $time, shape_code);
                mismatches++;
            end
            else
            begin
                want_shape = pending_shapes.pop_front();
                if (shape_code !== want_shape)
                begin
                    $display("%0t: shape_code expected %0d actual %0d",
                             $time, want_shape, shape_code);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        quad_t q;
        mix_t  kind;
        int    ox [4];
        int    oy [4];
        int    bx;
        int    by;
        int    ux;
        int    uy;
        int    vx;
        int    vy;
        int    k;
        int    j;
        int    tmp;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_DIR; r++)
        begin
            for (int i = 0; i < 8; i++)
                q[i] = COORD_W'(dir_tab[r][i]);
            send_item(q, dir_tab[r][8], 1'b0);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            kind = mix_t'($urandom_range(0, int'(MIX_CORNER)));
            bx = int'($urandom_range(0, 32000)) - 16000;
            by = int'($urandom_range(0, 32000)) - 16000;
            ux = int'($urandom_range(0, 6000)) - 3000;
            uy = int'($urandom_range(0, 6000)) - 3000;
            vx = int'($urandom_range(0, 6000)) - 3000;
            vy = int'($urandom_range(0, 6000)) - 3000;
            k  = $urandom_range(2, 3);
            ox[0] = 0;
            oy[0] = 0;
            unique case (kind)
                MIX_SQUARE:
                begin
                    ox[1] = ux;      oy[1] = uy;
                    ox[2] = ux - uy; oy[2] = uy + ux;
                    ox[3] = -uy;     oy[3] = ux;
                end
                MIX_RECT:
                begin
                    ox[1] = ux;          oy[1] = uy;
                    ox[2] = ux - k * uy; oy[2] = uy + k * ux;
                    ox[3] = -k * uy;     oy[3] = k * ux;
                end
                MIX_RHOMBUS:
                begin
                    ox[1] = ux;      oy[1] = uy;
                    ox[2] = ux + uy; oy[2] = uy + ux;
                    ox[3] = uy;      oy[3] = ux;
                end
                MIX_PARA:
                begin
                    ox[1] = ux;      oy[1] = uy;
                    ox[2] = ux + vx; oy[2] = uy + vy;
                    ox[3] = vx;      oy[3] = vy;
                end
                MIX_TRAP:
                begin
                    ox[1] = k * ux;  oy[1] = k * uy;
                    ox[2] = vx + ux; oy[2] = vy + uy;
                    ox[3] = vx;      oy[3] = vy;
                end
                MIX_LINE:
                    for (int i = 0; i < 4; i++)
                    begin
                        tmp = int'($urandom_range(0, 4)) - 2;
                        ox[i] = tmp * ux;
                        oy[i] = tmp * uy;
                    end
                MIX_GRID:
                    for (int i = 0; i < 4; i++)
                    begin
                        ox[i] = int'($urandom_range(0, 6)) - 3;
                        oy[i] = int'($urandom_range(0, 6)) - 3;
                    end
                MIX_WIDE:
                begin
                    bx = 0;
                    by = 0;
                    for (int i = 0; i < 4; i++)
                    begin
                        ox[i] = $urandom;
                        oy[i] = $urandom;
                    end
                end
                default:
                begin
                    bx = 0;
                    by = 0;
                    for (int i = 0; i < 4; i++)
                    begin
                        ox[i] = rim_vals[$urandom_range(0, 6)];
                        oy[i] = rim_vals[$urandom_range(0, 6)];
                    end
                end
            endcase
            // Shuffle the corners so that both reordering swaps are exercised.
            for (int i = 3; i > 0; i--)
            begin
                j = $urandom_range(0, i);
                tmp = ox[i]; ox[i] = ox[j]; ox[j] = tmp;
                tmp = oy[i]; oy[i] = oy[j]; oy[j] = tmp;
            end
            for (int i = 0; i < 4; i++)
            begin
                q[2*i]   = COORD_W'(bx + ox[i]);
                q[2*i+1] = COORD_W'(by + oy[i]);
            end
            send_item(q, USE_MODEL, n >= RANDOM_ITEMS - QUIET_TAIL);
        end
        start <= 1'b0;

        while (pending_shapes.size() != 0)
            @(posedge clk);
        repeat (qsc_pkg::PIPE_DEPTH + 4) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #(WATCHDOG);
        $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/qsc_pkg.sv
rtl/qsc_sign_lane.sv
rtl/qsc_len_lane.sv
rtl/qsc_classify.sv
rtl/quadrilateral_shape_classifier.sv
verif/tb_quadrilateral_shape_classifier.sv
